/* hdl/alpha_beta_gamma_tracker_top_macros.svh */
// Assertion macros used by the tracker sequencer.
`ifndef ALPHA_BETA_GAMMA_TRACKER_TOP_MACROS_SVH
`define ALPHA_BETA_GAMMA_TRACKER_TOP_MACROS_SVH

// Checked only while out of reset.
`define ABGT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ABGT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hdl/abgt_pkg.sv */
package abgt_pkg;

  localparam int NUM_AXES = 3;
  localparam int DATA_W   = 32;
  localparam int AXIS_W   = $clog2(NUM_AXES);
  localparam int ADDR_W   = 5;
  localparam int PC_W     = 5;
  localparam int UCODE_LEN = 17;

  localparam longint PI_Q30_X2 = 64'sd6746518852;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [2:0] {
    REG_ALPHA,
    REG_BETA,
    REG_GAMMA,
    REG_STEP,
    REG_HALF_SQ,
    REG_ANGULAR
  } reg_idx_e;

  typedef struct packed {
    logic [16:0] alpha;
    logic [31:0] beta;
    logic [31:0] gamma;
    logic [16:0] step;
    logic [15:0] half_sq;
    logic        angular;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_MUL,
    OP_ACC,
    OP_RES,
    OP_WRAP,
    OP_WEND,
    OP_RSAT,
    OP_NEXT
  } op_e;

  typedef enum logic [2:0] {
    G_STEP,
    G_HALF_SQ,
    G_ALPHA,
    G_BETA,
    G_GAMMA
  } gain_sel_e;

  typedef enum logic [1:0] {
    V_ACC,
    V_VEL,
    V_RES
  } val_sel_e;

  typedef enum logic [2:0] {
    A_POS,
    A_VEL,
    A_ACC,
    A_TMP,
    A_PPRED,
    A_VPRED
  } add_sel_e;

  typedef enum logic [2:0] {
    D_POS,
    D_VEL,
    D_ACC,
    D_TMP,
    D_PPRED,
    D_VPRED
  } dst_e;

  typedef enum logic [1:0] {
    J_NONE,
    J_LINEAR,
    J_LOOP,
    J_AXIS
  } jump_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    op_e             op;
    gain_sel_e       gsel;
    val_sel_e        vsel;
    add_sel_e        asrc;
    dst_e            dst;
    jump_e           jump;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_e               op;
    gain_sel_e         gsel;
    val_sel_e          vsel;
    add_sel_e          asrc;
    dst_e              dst;
    logic [AXIS_W-1:0] axis;
    logic              load_meas;
    logic              load_out;
  } ctrl_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

  localparam logic [PC_W-1:0] PC_START = 5'd0;
  localparam logic [PC_W-1:0] PC_WRAP  = 5'd7;
  localparam logic [PC_W-1:0] PC_RSAT  = 5'd9;

  function automatic longint pi_q(input int frac);
    return ((PI_Q30_X2 >>> (30 - frac)) + 1) >>> 1;
  endfunction

  // Smallest k with (2*pi << k) at or above 2^33.
  function automatic int wrap_k(input int frac);
    longint tp;
    int     k;
    tp = 2 * pi_q(frac);
    k  = 0;
    for (int i = 0; i < 40; i++) begin
      if ((tp << k) < (longint'(1) << 33)) begin
        k = k + 1;
      end
    end
    return k;
  endfunction

  function automatic uword_t uw(input op_e op, input gain_sel_e g, input val_sel_e v,
                                input add_sel_e a, input dst_e d, input jump_e j,
                                input logic [PC_W-1:0] t);
    uword_t w;
    w.op     = op;
    w.gsel   = g;
    w.vsel   = v;
    w.asrc   = a;
    w.dst    = d;
    w.jump   = j;
    w.target = t;
    return w;
  endfunction

  // One axis of the filter: predict, residual, optional wrap, correct.
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      5'd0:    w = uw(OP_MUL,  G_STEP,    V_ACC, A_POS,   D_POS,   J_NONE,   PC_START);
      5'd1:    w = uw(OP_ACC,  G_STEP,    V_ACC, A_VEL,   D_VPRED, J_NONE,   PC_START);
      5'd2:    w = uw(OP_MUL,  G_STEP,    V_VEL, A_POS,   D_POS,   J_NONE,   PC_START);
      5'd3:    w = uw(OP_ACC,  G_STEP,    V_ACC, A_POS,   D_TMP,   J_NONE,   PC_START);
      5'd4:    w = uw(OP_MUL,  G_HALF_SQ, V_ACC, A_POS,   D_POS,   J_NONE,   PC_START);
      5'd5:    w = uw(OP_ACC,  G_STEP,    V_ACC, A_TMP,   D_PPRED, J_NONE,   PC_START);
      5'd6:    w = uw(OP_RES,  G_STEP,    V_ACC, A_POS,   D_POS,   J_LINEAR, PC_RSAT);
      5'd7:    w = uw(OP_WRAP, G_STEP,    V_ACC, A_POS,   D_POS,   J_LOOP,   PC_WRAP);
      5'd8:    w = uw(OP_WEND, G_STEP,    V_ACC, A_POS,   D_POS,   J_NONE,   PC_START);
      5'd9:    w = uw(OP_RSAT, G_STEP,    V_ACC, A_POS,   D_POS,   J_NONE,   PC_START);
      5'd10:   w = uw(OP_MUL,  G_ALPHA,   V_RES, A_POS,   D_POS,   J_NONE,   PC_START);
      5'd11:   w = uw(OP_ACC,  G_STEP,    V_ACC, A_PPRED, D_POS,   J_NONE,   PC_START);
      5'd12:   w = uw(OP_MUL,  G_BETA,    V_RES, A_POS,   D_POS,   J_NONE,   PC_START);
      5'd13:   w = uw(OP_ACC,  G_STEP,    V_ACC, A_VPRED, D_VEL,   J_NONE,   PC_START);
      5'd14:   w = uw(OP_MUL,  G_GAMMA,   V_RES, A_POS,   D_POS,   J_NONE,   PC_START);
      5'd15:   w = uw(OP_ACC,  G_STEP,    V_ACC, A_ACC,   D_ACC,   J_NONE,   PC_START);
      5'd16:   w = uw(OP_NEXT, G_STEP,    V_ACC, A_POS,   D_POS,   J_AXIS,   PC_START);
      default: w = uw(OP_NEXT, G_STEP,    V_ACC, A_POS,   D_POS,   J_AXIS,   PC_START);
    endcase
    return w;
  endfunction

endpackage

/* hdl/abgt_meas_if.sv */
interface abgt_meas_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] meas_x;
  logic signed [31:0] meas_y;
  logic signed [31:0] meas_z;

  modport source(output valid, output meas_x, output meas_y, output meas_z, input ready);
  modport sink(input valid, input meas_x, input meas_y, input meas_z, output ready);
endinterface

/* hdl/abgt_est_if.sv */
interface abgt_est_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [31:0] acc_x;
  logic signed [31:0] acc_y;
  logic signed [31:0] acc_z;

  modport source(output valid, output pos_x, output pos_y, output pos_z,
                 output vel_x, output vel_y, output vel_z,
                 output acc_x, output acc_y, output acc_z, input ready);
  modport sink(input valid, input pos_x, input pos_y, input pos_z,
               input vel_x, input vel_y, input vel_z,
               input acc_x, input acc_y, input acc_z, output ready);
endinterface

/* hdl/abgt_regs.sv */
module abgt_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [abgt_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output abgt_pkg::cfg_t              cfg_o
);
  import abgt_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;

  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      case (idx)
        REG_ALPHA:   cfg_d.alpha   = pwdata[16:0];
        REG_BETA:    cfg_d.beta    = pwdata;
        REG_GAMMA:   cfg_d.gamma   = pwdata;
        REG_STEP:    cfg_d.step    = pwdata[16:0];
        REG_HALF_SQ: cfg_d.half_sq = pwdata[15:0];
        REG_ANGULAR: cfg_d.angular = pwdata[0];
        default:     cfg_d         = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ALPHA:   prdata = {15'd0, cfg_q.alpha};
      REG_BETA:    prdata = cfg_q.beta;
      REG_GAMMA:   prdata = cfg_q.gamma;
      REG_STEP:    prdata = {15'd0, cfg_q.step};
      REG_HALF_SQ: prdata = {16'd0, cfg_q.half_sq};
      REG_ANGULAR: prdata = {31'd0, cfg_q.angular};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha   <= 17'd52429;
      cfg_q.beta    <= 32'd327680;
      cfg_q.gamma   <= 32'd1310720;
      cfg_q.step    <= 17'd655;
      cfg_q.half_sq <= 16'd3;
      cfg_q.angular <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

/* hdl/abgt_dpath.sv */
module abgt_dpath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  abgt_pkg::cfg_t                                cfg_i,
  input  abgt_pkg::ctrl_t                               ctrl_i,
  input  logic [abgt_pkg::NUM_AXES-1:0][31:0]           meas_i,
  output logic [abgt_pkg::NUM_AXES-1:0][31:0]           pos_o,
  output logic [abgt_pkg::NUM_AXES-1:0][31:0]           vel_o,
  output logic [abgt_pkg::NUM_AXES-1:0][31:0]           acc_o,
  output logic                                          out_valid_o,
  input  logic                                          out_ready_i,
  output abgt_pkg::stat_t                               stat_o
);
  import abgt_pkg::*;

  localparam longint PI_Q   = pi_q(FRAC_BITS);
  localparam int     WRAP_K = wrap_k(FRAC_BITS);
  localparam int     PROD_W = 65;
  localparam int     SUM_W  = 67 - FRAC_BITS;
  localparam int     W_W    = 36;

  localparam logic signed [PROD_W-1:0] HALF   = PROD_W'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [W_W-1:0]    PI_W   = W_W'(PI_Q);
  localparam logic signed [W_W-1:0]    SPAN_W = W_W'((2 * PI_Q) << WRAP_K);
  localparam logic signed [SUM_W-1:0]  MAX_S  = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0]  MIN_S  = SUM_W'(-64'sd2147483648);

  function automatic word_t sat32(input logic signed [SUM_W-1:0] x);
    word_t y;
    if (x > MAX_S) begin
      y = 32'sh7FFFFFFF;
    end else if (x < MIN_S) begin
      y = 32'sh80000000;
    end else begin
      y = word_t'(x[31:0]);
    end
    return y;
  endfunction

  word_t                    p_q [NUM_AXES];
  word_t                    v_q [NUM_AXES];
  word_t                    a_q [NUM_AXES];
  word_t                    meas_q [NUM_AXES];
  word_t                    pos_q [NUM_AXES];
  word_t                    vel_q [NUM_AXES];
  word_t                    acc_q [NUM_AXES];
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [SUM_W-1:0]  tmp_q;
  word_t                    pp_q;
  word_t                    vp_q;
  word_t                    r_q;
  logic signed [W_W-1:0]    w_q;
  logic signed [W_W-1:0]    d_q;
  logic                     out_valid_q;
  logic                     out_valid_d;

  logic [31:0]              gain;
  word_t                    val;
  logic signed [32:0]       mul_a;
  logic signed [PROD_W-1:0] rnd_full;
  logic signed [SUM_W-1:0]  rnd;
  logic signed [SUM_W-1:0]  addend;
  logic signed [SUM_W-1:0]  sum;
  word_t                    sum_sat;
  logic signed [W_W-1:0]    res;
  logic signed [W_W-1:0]    res_n;
  logic [AXIS_W-1:0]        ax;

  assign ax = ctrl_i.axis;

  always_comb begin
    case (ctrl_i.gsel)
      G_STEP:    gain = {15'd0, cfg_i.step};
      G_HALF_SQ: gain = {16'd0, cfg_i.half_sq};
      G_ALPHA:   gain = {15'd0, cfg_i.alpha};
      G_BETA:    gain = cfg_i.beta;
      G_GAMMA:   gain = cfg_i.gamma;
      default:   gain = '0;
    endcase
    case (ctrl_i.vsel)
      V_ACC:   val = a_q[ax];
      V_VEL:   val = v_q[ax];
      V_RES:   val = r_q;
      default: val = '0;
    endcase
    case (ctrl_i.asrc)
      A_POS:   addend = SUM_W'(p_q[ax]);
      A_VEL:   addend = SUM_W'(v_q[ax]);
      A_ACC:   addend = SUM_W'(a_q[ax]);
      A_TMP:   addend = tmp_q;
      A_PPRED: addend = SUM_W'(pp_q);
      A_VPRED: addend = SUM_W'(vp_q);
      default: addend = '0;
    endcase
  end

  assign mul_a    = $signed({1'b0, gain});
  assign prod_d   = PROD_W'(mul_a) * PROD_W'(val);
  assign rnd_full = (prod_q + HALF) >>> FRAC_BITS;
  assign rnd      = SUM_W'(rnd_full);
  assign sum      = addend + rnd;
  assign sum_sat  = sat32(sum);
  assign res      = W_W'(meas_q[ax]) - W_W'(pp_q);
  assign res_n    = res + PI_W;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        p_q[i] <= '0;
        v_q[i] <= '0;
        a_q[i] <= '0;
      end
    end else if (ctrl_i.op == OP_ACC) begin
      case (ctrl_i.dst)
        D_POS:   p_q[ax] <= sum_sat;
        D_VEL:   v_q[ax] <= sum_sat;
        D_ACC:   a_q[ax] <= sum_sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_meas) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        meas_q[i] <= word_t'(meas_i[i]);
      end
    end
    if (ctrl_i.load_out) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        pos_q[i] <= p_q[i];
        vel_q[i] <= v_q[i];
        acc_q[i] <= a_q[i];
      end
    end
    case (ctrl_i.op)
      OP_MUL: prod_q <= prod_d;
      OP_ACC: begin
        case (ctrl_i.dst)
          D_TMP:   tmp_q <= sum;
          D_PPRED: pp_q  <= sum_sat;
          D_VPRED: vp_q  <= sum_sat;
          default: ;
        endcase
      end
      OP_RES: begin
        if (cfg_i.angular) begin
          w_q <= (res_n < 0) ? res_n + SPAN_W : res_n;
        end else begin
          w_q <= res;
        end
        d_q <= SPAN_W;
      end
      OP_WRAP: begin
        if (w_q >= d_q) begin
          w_q <= w_q - d_q;
        end
        d_q <= d_q >>> 1;
      end
      OP_WEND: w_q <= w_q - PI_W;
      OP_RSAT: r_q <= sat32(SUM_W'(w_q));
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      pos_o[i] = pos_q[i];
      vel_o[i] = vel_q[i];
      acc_o[i] = acc_q[i];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.out_busy = out_valid_q && !out_ready_i;

endmodule

/* hdl/abgt_seq.sv */
`include "alpha_beta_gamma_tracker_top_macros.svh"

module abgt_seq #(
  parameter int FRAC_BITS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  abgt_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  abgt_pkg::stat_t stat_i,
  output abgt_pkg::ctrl_t ctrl_o
);
  import abgt_pkg::*;

  localparam int WRAP_K = wrap_k(FRAC_BITS);
  localparam int CNT_W  = $clog2(WRAP_K + 1);

  state_e            state_q;
  state_e            state_d;
  logic [PC_W-1:0]   pc_q;
  logic [PC_W-1:0]   pc_d;
  logic [AXIS_W-1:0] ax_q;
  logic [AXIS_W-1:0] ax_d;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  cnt_d;
  uword_t            uw;

  assign uw = ucode_rom(pc_q);

  always_comb begin
    state_d          = state_q;
    pc_d             = pc_q;
    ax_d             = ax_q;
    cnt_d            = cnt_q;
    in_ready_o       = 1'b0;
    ctrl_o.op        = OP_NEXT;
    ctrl_o.gsel      = uw.gsel;
    ctrl_o.vsel      = uw.vsel;
    ctrl_o.asrc      = uw.asrc;
    ctrl_o.dst       = uw.dst;
    ctrl_o.axis      = ax_q;
    ctrl_o.load_meas = 1'b0;
    ctrl_o.load_out  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load_meas = 1'b1;
          state_d          = ST_RUN;
          pc_d             = PC_START;
          ax_d             = '0;
        end
      end
      ST_RUN: begin
        ctrl_o.op = uw.op;
        if (uw.op == OP_RES) begin
          cnt_d = CNT_W'(WRAP_K);
        end
        case (uw.jump)
          J_NONE: pc_d = pc_q + 1'b1;
          J_LINEAR: begin
            pc_d = cfg_i.angular ? pc_q + 1'b1 : uw.target;
          end
          J_LOOP: begin
            if (cnt_q != '0) begin
              pc_d  = uw.target;
              cnt_d = cnt_q - 1'b1;
            end else begin
              pc_d = pc_q + 1'b1;
            end
          end
          J_AXIS: begin
            if (ax_q != AXIS_W'(NUM_AXES - 1)) begin
              ax_d = ax_q + 1'b1;
              pc_d = uw.target;
            end else if (!stat_i.out_busy) begin
              ctrl_o.load_out = 1'b1;
              state_d         = ST_IDLE;
            end
          end
          default: pc_d = pc_q + 1'b1;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= PC_START;
      ax_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      ax_q    <= ax_d;
      cnt_q   <= cnt_d;
    end
  end

  `ABGT_ASSERT(a_start_at_top, (state_q == ST_IDLE && in_valid_i) |=> (state_q == ST_RUN && pc_q == PC_START && ax_q == '0), "request did not start the program at axis zero")
  `ABGT_ASSERT(a_pc_in_rom, (state_q == ST_RUN) |-> (pc_q < PC_W'(UCODE_LEN)), "step counter left the program")
  `ABGT_ASSERT(a_loop_counts_down, (state_q == ST_RUN && uw.jump == J_LOOP && cnt_q != '0) |=> (cnt_q == $past(cnt_q) - 1'b1), "wrap loop counter did not step down")
  `ABGT_ASSERT(a_no_overwrite, ctrl_o.load_out |-> !stat_i.out_busy, "result register overwritten while held")

endmodule

/* hdl/alpha_beta_gamma_tracker_top.sv */
// Each accepted request runs the program once per axis: predict, residual, angle wrap
// (angular mode only), correct. The result is presented once the last axis is done and
// the previous result has been taken; then a new request can be accepted. The pace is
// set by the single shared multiplier and the one-step-per-cycle angle reduction loop.
// Reset clears all estimates and loads the register defaults; no clearing pass is needed.
module alpha_beta_gamma_tracker_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  abgt_meas_if.sink                   meas_i,
  abgt_est_if.source                  est_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [abgt_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import abgt_pkg::*;

  cfg_t                        cfg;
  ctrl_t                       ctrl;
  stat_t                       stat;
  logic [NUM_AXES-1:0][31:0]   meas;
  logic [NUM_AXES-1:0][31:0]   pos;
  logic [NUM_AXES-1:0][31:0]   vel;
  logic [NUM_AXES-1:0][31:0]   acc;
  logic                        out_valid;
  logic                        in_ready;

  assign meas[0] = meas_i.meas_x;
  assign meas[1] = meas_i.meas_y;
  assign meas[2] = meas_i.meas_z;
  assign meas_i.ready = in_ready;

  assign est_o.valid = out_valid;
  assign est_o.pos_x = pos[0];
  assign est_o.pos_y = pos[1];
  assign est_o.pos_z = pos[2];
  assign est_o.vel_x = vel[0];
  assign est_o.vel_y = vel[1];
  assign est_o.vel_z = vel[2];
  assign est_o.acc_x = acc[0];
  assign est_o.acc_y = acc[1];
  assign est_o.acc_z = acc[2];

  abgt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  abgt_seq #(
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (meas_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  abgt_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .ctrl_i      (ctrl),
    .meas_i      (meas),
    .pos_o       (pos),
    .vel_o       (vel),
    .acc_o       (acc),
    .out_valid_o (out_valid),
    .out_ready_i (est_o.ready),
    .stat_o      (stat)
  );

endmodule

/* tb/sv/tb_alpha_beta_gamma_tracker_top.sv */
`timescale 1ns / 100ps

module tb_alpha_beta_gamma_tracker_top;
  import abgt_pkg::*;

  typedef logic [2:0][31:0] meas_vec_t;
  typedef logic [8:0][31:0] est_vec_t;

  typedef struct {
    int        set_id;
    meas_vec_t m;
    bit        typed;
    est_vec_t  want;
  } stim_row_t;

  localparam int     FRAC_BITS      = 16;
  localparam longint ROUND_HALF     = 64'sd1 <<< (FRAC_BITS - 1);
  localparam longint WORD_MAX       = 64'sd2147483647;
  localparam longint WORD_MIN       = -64'sd2147483648;
  // Pi rounded to sixteen fraction bits.
  localparam longint PI_FIX         = 64'sd205887;
  localparam longint TWO_PI_FIX     = 2 * PI_FIX;
  localparam int     WATCHDOG_LIMIT = 5000;
  localparam int     RAND_PHASES    = 13;
  localparam int     PHASE_ITEMS    = 100;
  localparam int     TAIL_CYCLES    = 120;

  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  localparam int SET_RESET = 0;
  localparam int SET_UNITY = 1;
  localparam int SET_MAX   = 2;
  localparam int SET_ANGLE = 3;
  localparam int SET_ZERO  = 4;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  abgt_meas_if meas_if ();
  abgt_est_if  est_if ();

  alpha_beta_gamma_tracker_top i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .meas_i  (meas_if),
    .est_o   (est_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cfg_t      trk_cfg;
  word_t     trk_pos [3];
  word_t     trk_vel [3];
  word_t     trk_acc [3];
  est_vec_t  pending_est [$];
  stim_row_t dir_rows [$];
  cfg_t      dir_cfg [5];
  string     est_names [9] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z",
                               "acc_x", "acc_y", "acc_z"};

  bit     calm;
  int     fails;
  int     sent;
  int     checked;
  int     angular_sent;
  int     settings_applied;
  int     rx_hold;
  int     stall_cycles;
  longint traj_p [3];
  longint traj_v [3];

  function automatic longint sat_word(input longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  function automatic longint scale_round(input longint gain, input longint v);
    return (gain * v + ROUND_HALF) >>> FRAC_BITS;
  endfunction

  function automatic est_vec_t advance_tracker(input meas_vec_t m);
    est_vec_t res;
    longint   p, v, a, mv, vp, pp, r, n, q;
    for (int ax = 0; ax < 3; ax++) begin
      p  = longint'(trk_pos[ax]);
      v  = longint'(trk_vel[ax]);
      a  = longint'(trk_acc[ax]);
      mv = longint'($signed(m[ax]));
      vp = sat_word(v + scale_round(longint'(trk_cfg.step), a));
      pp = sat_word(p + scale_round(longint'(trk_cfg.step), v) +
                    scale_round(longint'(trk_cfg.half_sq), a));
      r  = mv - pp;
      if (trk_cfg.angular) begin
        // Floor division keeps the wrapped residual in [-pi, pi).
        n = r + PI_FIX;
        q = n / TWO_PI_FIX;
        if ((n % TWO_PI_FIX) != 0 && n < 0) q = q - 1;
        r = r - q * TWO_PI_FIX;
      end
      r = sat_word(r);
      trk_pos[ax] = word_t'(sat_word(pp + scale_round(longint'(trk_cfg.alpha), r)));
      trk_vel[ax] = word_t'(sat_word(vp + scale_round(longint'(trk_cfg.beta), r)));
      trk_acc[ax] = word_t'(sat_word(a + scale_round(longint'(trk_cfg.gamma), r)));
      res[ax]     = trk_pos[ax];
      res[3 + ax] = trk_vel[ax];
      res[6 + ax] = trk_acc[ax];
    end
    return res;
  endfunction

  function automatic cfg_t make_cfg(input logic [16:0] al, input logic [31:0] be,
                                    input logic [31:0] ga, input logic [16:0] st,
                                    input logic [15:0] hs, input logic ang);
    cfg_t c;
    c.alpha   = al;
    c.beta    = be;
    c.gamma   = ga;
    c.step    = st;
    c.half_sq = hs;
    c.angular = ang;
    return c;
  endfunction

  function automatic cfg_t rand_cfg(input int phase);
    logic [16:0] al, st;
    logic [31:0] be, ga;
    logic [15:0] hs;
    longint      sq;
    if (phase == 0) begin
      return make_cfg(17'h1FFFF, '1, '1, 17'h1FFFF, '1, 1'($urandom_range(0, 1)));
    end
    if (phase == 1) return make_cfg('0, '0, '0, '0, '0, 1'($urandom_range(0, 1)));
    al = ($urandom_range(0, 9) == 0) ? 17'($urandom_range(0, 131071)) :
                                       17'($urandom_range(0, 65536));
    be = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 20 << 16);
    ga = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 200 << 16);
    if ($urandom_range(0, 9) == 0) st = 17'($urandom_range(0, 131071));
    else if ($urandom_range(0, 1) == 0) st = 17'($urandom_range(0, 6554));
    else st = 17'($urandom_range(0, 65536));
    sq = (longint'(st) * longint'(st)) >>> 17;
    hs = ($urandom_range(0, 4) == 0 || sq > 65535) ? 16'($urandom_range(0, 65535)) :
                                                    16'(sq);
    return make_cfg(al, be, ga, st, hs, 1'($urandom_range(0, 1)));
  endfunction

  function automatic longint srand(input longint span);
    longint u;
    u = longint'($urandom_range(0, 32'(2 * span)));
    return u - span;
  endfunction

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 120);
  endfunction

  function automatic void note_fail(input string msg);
    fails++;
    if (fails <= 10) $display("%s", msg);
  endfunction

  task automatic add_row(input int set_id, input word_t x, input word_t y, input word_t z,
                         input bit typed = 1'b0, input word_t px = '0, input word_t py = '0,
                         input word_t pz = '0);
    stim_row_t row;
    row.set_id = set_id;
    row.m      = {z, y, x};
    row.typed  = typed;
    row.want   = '0;
    row.want[0] = px;
    row.want[1] = py;
    row.want[2] = pz;
    dir_rows.push_back(row);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ALPHA:   trk_cfg.alpha   = val[16:0];
      REG_BETA:    trk_cfg.beta    = val;
      REG_GAMMA:   trk_cfg.gamma   = val;
      REG_STEP:    trk_cfg.step    = val[16:0];
      REG_HALF_SQ: trk_cfg.half_sq = val[15:0];
      REG_ANGULAR: trk_cfg.angular = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Bits above each register's width carry noise and must be dropped.
  task automatic apply_cfg(input cfg_t c);
    write_reg(REG_ALPHA, {15'($urandom()), c.alpha});
    write_reg(REG_BETA, c.beta);
    write_reg(REG_GAMMA, c.gamma);
    write_reg(REG_STEP, {15'($urandom()), c.step});
    write_reg(REG_HALF_SQ, {16'($urandom()), c.half_sq});
    write_reg(REG_ANGULAR, {31'($urandom()), c.angular});
    settings_applied++;
  endtask

  task automatic hold_meas();
    meas_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_est.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_meas(input meas_vec_t m, input bit typed, input est_vec_t want);
    est_vec_t pred;
    int       gap;
    gap = gap_len();
    if (gap > 0) begin
      meas_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    meas_if.valid  <= 1'b1;
    meas_if.meas_x <= m[0];
    meas_if.meas_y <= m[1];
    meas_if.meas_z <= m[2];
    do @(posedge clk_i); while (!meas_if.ready);
    if (trk_cfg.angular) angular_sent++;
    pred = advance_tracker(m);
    pending_est.push_back(typed ? want : pred);
    sent++;
  endtask

  task automatic send_random_meas();
    meas_vec_t m;
    longint    span;
    span = trk_cfg.angular ? PI_FIX : (64'sd1 <<< 26);
    for (int ax = 0; ax < 3; ax++) begin
      traj_v[ax] = traj_v[ax] + srand(span >>> 14);
      traj_p[ax] = traj_p[ax] + traj_v[ax];
      m[ax] = 32'(sat_word(traj_p[ax] + srand(span >>> 8)));
    end
    if ($urandom_range(0, 99) < 15) m = {$urandom(), $urandom(), $urandom()};
    send_meas(m, 1'b0, '0);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    est_vec_t got, want;
    if (rst_ni && est_if.valid && est_if.ready) begin
      got = {est_if.acc_z, est_if.acc_y, est_if.acc_x, est_if.vel_z, est_if.vel_y,
             est_if.vel_x, est_if.pos_z, est_if.pos_y, est_if.pos_x};
      if (pending_est.size() == 0) begin
        note_fail($sformatf("estimate %0d arrived with no request outstanding", checked));
      end else begin
        want = pending_est.pop_front();
        for (int f = 0; f < 9; f++) begin
          if (got[f] !== want[f]) begin
            note_fail($sformatf("estimate %0d, %s: expected %h, got %h", checked,
                                est_names[f], want[f], got[f]));
          end
        end
      end
      checked++;
    end
    if (rx_hold > 0) begin
      est_if.ready <= 1'b0;
      rx_hold      <= rx_hold - 1;
    end else begin
      est_if.ready <= 1'b1;
      rx_hold      <= gap_len();
    end
  end

  always @(posedge clk_i) begin
    if ((meas_if.valid && meas_if.ready) || (est_if.valid && est_if.ready) || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request accepted for %0d cycles", stall_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int cur_set;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    meas_if.valid  = 1'b0;
    meas_if.meas_x = '0;
    meas_if.meas_y = '0;
    meas_if.meas_z = '0;
    est_if.ready   = 1'b0;
    rx_hold        = 0;
    stall_cycles   = 0;
    calm           = 1'b0;
    trk_cfg        = make_cfg(17'd52429, 32'd327680, 32'd1310720, 17'd655, 16'd3, 1'b0);
    for (int ax = 0; ax < 3; ax++) begin
      trk_pos[ax] = '0;
      trk_vel[ax] = '0;
      trk_acc[ax] = '0;
    end

    dir_cfg[SET_RESET] = trk_cfg;
    dir_cfg[SET_UNITY] = make_cfg(17'd65536, '0, '0, '0, '0, 1'b0);
    dir_cfg[SET_MAX]   = make_cfg(17'h1FFFF, '1, '1, 17'h1FFFF, '1, 1'b0);
    dir_cfg[SET_ANGLE] = make_cfg(17'd65536, 32'd65536, 32'd32768, 17'd655, 16'd3, 1'b1);
    dir_cfg[SET_ZERO]  = make_cfg('0, '0, '0, '0, '0, 1'b0);

    // A zero measurement from the cleared state leaves every estimate at zero.
    add_row(SET_RESET, 0, 0, 0, 1'b1);
    add_row(SET_RESET, 0, 0, 0, 1'b1);
    // Unity position gain with all other gains zero copies the measurement.
    add_row(SET_UNITY, 32'h7FFFFFFF, 32'h80000000, 0, 1'b1, 32'h7FFFFFFF, 32'h80000000, 0);
    // The residual saturates before the unity gain is applied.
    add_row(SET_UNITY, 32'h80000000, 32'h7FFFFFFF, 32'h00012345, 1'b1,
            32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00012345);
    add_row(SET_UNITY, 32'h40000000, 32'hC0000000, 32'hFFFFFFFF);
    add_row(SET_RESET, 32'h00010000, 32'hFFFF0000, 32'h00A00000);
    add_row(SET_RESET, 32'h7FFFFFFF, 32'h80000000, 32'h55555555);
    add_row(SET_RESET, 32'h80000000, 32'h7FFFFFFF, 32'hAAAAAAAA);
    add_row(SET_MAX, 32'h7FFFFFFF, 32'h80000000, 0);
    add_row(SET_MAX, 0, 32'h7FFFFFFF, 32'h80000000);
    add_row(SET_MAX, 32'h12345678, 32'hEDCBA988, 1);
    add_row(SET_ANGLE, word_t'(PI_FIX), word_t'(-PI_FIX), word_t'(PI_FIX - 1));
    add_row(SET_ANGLE, 32'h7FFFFFFF, 32'h80000000, 0);
    add_row(SET_ANGLE, 0, word_t'(PI_FIX + 1), word_t'(-PI_FIX - 1));
    add_row(SET_ANGLE, 32'h80000000, 32'h7FFFFFFF, 32'h0003243F);
    add_row(SET_ZERO, 32'h7FFFFFFF, 0, 32'h80000000);
    add_row(SET_ZERO, 1, 32'hFFFFFFFF, 0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Writes past the last register must leave the reset values in place.
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, 32'h5A5A5A5A);

    cur_set = SET_RESET;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_id != cur_set) begin
        hold_meas();
        wait_drained();
        apply_cfg(dir_cfg[dir_rows[i].set_id]);
        cur_set = dir_rows[i].set_id;
      end
      send_meas(dir_rows[i].m, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      hold_meas();
      wait_drained();
      apply_cfg(rand_cfg(ph));
      calm = ($urandom_range(0, 3) == 0);
      for (int ax = 0; ax < 3; ax++) begin
        traj_p[ax] = trk_cfg.angular ? srand(PI_FIX) : srand(64'sd1 <<< 26);
        traj_v[ax] = trk_cfg.angular ? srand(PI_FIX >>> 6) : srand(64'sd1 <<< 14);
      end
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 59) == 0) begin
          hold_meas();
          wait_drained();
        end
        send_random_meas();
      end
    end

    hold_meas();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_est.size() != 0) begin
      note_fail($sformatf("%0d estimates never arrived", pending_est.size()));
    end

    $display("%0d measurement requests (%0d directed, %0d in angular mode), %0d estimates checked",
             sent, dir_rows.size(), angular_sent, checked);
    $display("%0d register settings applied, %0d failures", settings_applied, fails);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
